// ===== rtl/core/scrd_pkg.sv =====
// Shared types, constants and helpers for the spherical camera ray direction block.
// Used by scrd_cordic and the top level; depends on nothing.
package scrd_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_PIXEL_SIZE   = 3'd2,
        CFG_MAX_AZIMUTH  = 3'd3,
        CFG_MAX_ELEV     = 3'd4,
        CFG_BASIS_RIGHT  = 3'd5,
        CFG_BASIS_UP     = 3'd6,
        CFG_BASIS_BACK   = 3'd7
    } t_cfg_idx;

    // Datapath widths
    localparam int ANG_W  = 25;   // angle in Q.16 degrees, [0, 360)
    localparam int Z_W    = 26;   // signed CORDIC angle
    localparam int XY_W   = 33;   // signed CORDIC x/y, Q1.30 with headroom
    localparam int DEN_W  = 45;   // pixel_size * resolution
    localparam int NUM_W  = 63;   // widest dividend
    localparam int QN_W   = 32;   // normalized coordinate, Q2.30, capped
    localparam int CORD_N = 16;   // CORDIC iterations

    // Angle constants in Q.16 degrees
    localparam logic [ANG_W-1:0] DEG_FULL    = 25'd23592960;
    localparam logic [ANG_W-1:0] DEG_HALF    = 25'd11796480;
    localparam logic [ANG_W-1:0] DEG_QUARTER = 25'd5898240;
    localparam logic signed [Z_W-1:0] Z_FULL    = 26'sd23592960;
    localparam logic signed [Z_W-1:0] Z_HALF    = 26'sd11796480;
    localparam logic signed [Z_W-1:0] Z_QUARTER = 26'sd5898240;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [QN_W-1:0] QN_CAP = 32'h8000_0000;

    // Arctangent of 2^-i in Q.16 degrees
    function automatic logic signed [Z_W-1:0] atan_deg(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            default: v = 26'sd115;
        endcase
        return v;
    endfunction

    // One signed Q2.14 component of a packed basis vector
    function automatic logic signed [15:0] comp16(input logic [47:0] vec, input int k);
        logic signed [15:0] c;
        c = vec[16*k +: 16];
        return c;
    endfunction

endpackage

// ===== rtl/core/scrd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; quotient kept modulo
// or saturated above QMAX. Caller must hold the divisor static (not enforced).
module scrd_div #(
    parameter int NW = 63,
    parameter int DW = 45,
    parameter int QW = 25,
    parameter bit SAT = 1'b0,
    parameter longint unsigned QMAX = 64'd23592960
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_q
);
    localparam logic [QW:0] QLIM = QMAX[QW:0];

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [QW-1:0] r_q   [NW];

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [DW-1:0] w_rem;
        logic [NW-1:0] w_num;
        logic [QW-1:0] w_q;
        logic [DW:0]   w_trial;
        logic          w_ge;
        logic [QW:0]   w_q2;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_q;

        if (s == 0) begin : g_first
            assign w_rem = '0;
            assign w_num = i_num;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_num = r_num[s-1];
            assign w_q   = r_q[s-1];
        end

        // one restoring step
        assign w_trial = {w_rem, w_num[NW-1]};
        assign w_ge    = (w_trial >= {1'b0, i_den});
        assign n_rem   = w_ge ? DW'(w_trial - {1'b0, i_den}) : w_trial[DW-1:0];
        assign w_q2    = {w_q, w_ge};

        // quotient accumulation: wrap or stick above the limit
        if (SAT) begin : g_sat
            assign n_q = (w_q2 > QLIM) ? QW'(QLIM + (QW+1)'(1)) : w_q2[QW-1:0];
        end else begin : g_mod
            assign n_q = (w_q2 >= QLIM) ? QW'(w_q2 - QLIM) : w_q2[QW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_num[s] <= {w_num[NW-2:0], 1'b0};
                r_q[s]   <= n_q;
            end
        end
    end

    assign o_q = r_q[NW-1];

endmodule

// ===== rtl/core/scrd_cordic.sv =====
// Pipelined rotation-mode CORDIC in Q.16 degrees: 16 iteration stages plus a
// sign stage. Uses scrd_pkg for widths, gain and the arctangent table.
module scrd_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [scrd_pkg::Z_W-1:0]     i_z,
    input  logic                                i_neg,
    output logic signed [scrd_pkg::XY_W-1:0]    o_cos,
    output logic signed [scrd_pkg::XY_W-1:0]    o_sin
);
    localparam int N = scrd_pkg::CORD_N;

    logic signed [scrd_pkg::XY_W-1:0] r_x [N];
    logic signed [scrd_pkg::XY_W-1:0] r_y [N];
    logic signed [scrd_pkg::Z_W-1:0]  r_z [N];
    logic                             r_n [N];
    logic signed [scrd_pkg::XY_W-1:0] r_cos;
    logic signed [scrd_pkg::XY_W-1:0] r_sin;

    for (genvar i = 0; i < N; i++) begin : g_it
        logic signed [scrd_pkg::XY_W-1:0] w_x;
        logic signed [scrd_pkg::XY_W-1:0] w_y;
        logic signed [scrd_pkg::Z_W-1:0]  w_z;
        logic                             w_n;
        logic signed [scrd_pkg::XY_W-1:0] w_dx;
        logic signed [scrd_pkg::XY_W-1:0] w_dy;
        logic signed [scrd_pkg::Z_W-1:0]  w_at;

        if (i == 0) begin : g_first
            assign w_x = scrd_pkg::CORDIC_GAIN;
            assign w_y = '0;
            assign w_z = i_z;
            assign w_n = i_neg;
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
            assign w_n = r_n[i-1];
        end

        assign w_dx = w_y >>> i;
        assign w_dy = w_x >>> i;
        assign w_at = scrd_pkg::atan_deg(i);

        // rotate toward zero residual angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_z[scrd_pkg::Z_W-1]) begin
                    r_x[i] <= w_x - w_dx;
                    r_y[i] <= w_y + w_dy;
                    r_z[i] <= w_z - w_at;
                end else begin
                    r_x[i] <= w_x + w_dx;
                    r_y[i] <= w_y - w_dy;
                    r_z[i] <= w_z + w_at;
                end
                r_n[i] <= w_n;
            end
        end
    end

    // undo the half-turn fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_n[N-1] ? -r_x[N-1] : r_x[N-1];
            r_sin <= r_n[N-1] ? -r_y[N-1] : r_y[N-1];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== rtl/core/spherical_camera_ray_direction.sv =====
// Spherical panoramic camera ray direction: sample offset in, Q2.14 ray out.
// Depends on scrd_pkg, scrd_div and scrd_cordic.
//
//  channel  dir  handshake                  payload
//  s        in   i_s_tvalid / o_s_tready    i_s_tdata: sample_x, sample_y
//  m        out  o_m_tvalid / i_m_tready    o_m_tdata: dir_x, dir_y, dir_z, inside_disk
//  cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat per cycle in, one per cycle out while the output is not stalled; an output
// beat passes 87 register stages after its input beat, among them the 63-stage dividers
// (one quotient bit each) and the 17-stage CORDIC.
// Reset clears the stage valid bits and loads the default configuration.
// A stall on the output freezes the whole pipeline; nothing is dropped.
module spherical_camera_ray_direction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] sample_x, [63:32] sample_y
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z,
                                     // [48] inside_disk, [55:49] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    localparam int DIV_N   = scrd_pkg::NUM_W;
    localparam int CORD_L  = scrd_pkg::CORD_N + 1;
    localparam int ST_PRE  = 1;
    localparam int ST_ANG  = ST_PRE + DIV_N + 1;
    localparam int ST_FOLD = ST_ANG + 1;
    localparam int LAT     = ST_FOLD + CORD_L + 4;

    // configuration registers
    logic [12:0] r_img_w, r_img_h;
    logic [31:0] r_pix;
    logic [15:0] r_max_az;
    logic [14:0] r_max_el;
    logic [47:0] r_bas_u, r_bas_v, r_bas_w;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 13'd640;
            r_img_h  <= 13'd480;
            r_pix    <= 32'd65536;
            r_max_az <= 16'd46080;
            r_max_el <= 15'd23040;
            r_bas_u  <= 48'd16384;
            r_bas_v  <= 48'd1073741824;
            r_bas_w  <= 48'd70368744177664;
        end else if (i_cfg_valid) begin
            unique case (scrd_pkg::t_cfg_idx'(i_cfg_index))
                scrd_pkg::CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[12:0];
                scrd_pkg::CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[12:0];
                scrd_pkg::CFG_PIXEL_SIZE:   r_pix    <= i_cfg_data[31:0];
                scrd_pkg::CFG_MAX_AZIMUTH:  r_max_az <= i_cfg_data[15:0];
                scrd_pkg::CFG_MAX_ELEV:     r_max_el <= i_cfg_data[14:0];
                scrd_pkg::CFG_BASIS_RIGHT:  r_bas_u  <= i_cfg_data;
                scrd_pkg::CFG_BASIS_UP:     r_bas_v  <= i_cfg_data;
                scrd_pkg::CFG_BASIS_BACK:   r_bas_w  <= i_cfg_data;
            endcase
        end
    end

    // image extents as divisors, zero taken as one
    logic [scrd_pkg::DEN_W-1:0] n_dw, n_dh, r_dw, r_dh;
    assign n_dw = scrd_pkg::DEN_W'(r_pix) * scrd_pkg::DEN_W'(r_img_w);
    assign n_dh = scrd_pkg::DEN_W'(r_pix) * scrd_pkg::DEN_W'(r_img_h);
    always_ff @(posedge i_clk) begin
        r_dw <= (n_dw == '0) ? scrd_pkg::DEN_W'(1) : n_dw;
        r_dh <= (n_dh == '0) ? scrd_pkg::DEN_W'(1) : n_dh;
    end

    // pipeline advance and valid bits
    logic           w_adv;
    logic [LAT-1:0] r_vld;
    assign w_adv      = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = w_adv;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // input register
    logic [31:0] r_sx, r_sy;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sx <= i_s_tdata[31:0];
            r_sy <= i_s_tdata[63:32];
        end
    end

    // magnitudes doubled, dividends for angle and normalized coordinates
    logic [32:0]       n_mx, n_my;
    logic [48:0]       n_lam_p, n_psi_p;
    logic [DIV_N-1:0]  r_num_lam, r_num_psi, r_num_qx, r_num_qy;
    logic [1:0]        r_sgn;
    assign n_mx = {(r_sx[31] ? (32'd0 - r_sx) : r_sx), 1'b0};
    assign n_my = {(r_sy[31] ? (32'd0 - r_sy) : r_sy), 1'b0};
    assign n_lam_p = 49'(n_mx) * 49'(r_max_az);
    assign n_psi_p = 49'(n_my) * 49'(r_max_el);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num_lam <= DIV_N'({n_lam_p, 8'd0});
            r_num_psi <= DIV_N'({n_psi_p, 8'd0});
            r_num_qx  <= DIV_N'({n_mx, 30'd0});
            r_num_qy  <= DIV_N'({n_my, 30'd0});
            r_sgn     <= {r_sy[31], r_sx[31]};
        end
    end

    // dividers
    logic [scrd_pkg::ANG_W-1:0] w_q_lam, w_q_psi;
    logic [scrd_pkg::QN_W-1:0]  w_q_qx, w_q_qy;

    scrd_div #(.NW(63), .DW(45), .QW(25), .SAT(1'b0), .QMAX(64'd23592960)) u_div_lam (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_num_lam), .i_den(r_dw), .o_q(w_q_lam)
    );
    scrd_div #(.NW(63), .DW(45), .QW(25), .SAT(1'b0), .QMAX(64'd23592960)) u_div_psi (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_num_psi), .i_den(r_dh), .o_q(w_q_psi)
    );
    scrd_div #(.NW(63), .DW(45), .QW(32), .SAT(1'b1), .QMAX(64'h8000_0000)) u_div_qx (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_num_qx), .i_den(r_dw), .o_q(w_q_qx)
    );
    scrd_div #(.NW(63), .DW(45), .QW(32), .SAT(1'b1), .QMAX(64'h8000_0000)) u_div_qy (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_num_qy), .i_den(r_dh), .o_q(w_q_qy)
    );

    // signs ride alongside the dividers
    logic [1:0] r_sgn_dly [DIV_N];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sgn_dly[0] <= r_sgn;
            for (int k = 1; k < DIV_N; k++) begin
                r_sgn_dly[k] <= r_sgn_dly[k-1];
            end
        end
    end

    // azimuth and polar angle, reduced to [0, 360)
    logic [scrd_pkg::ANG_W-1:0] n_lam, n_psi, n_phi, n_theta;
    logic [scrd_pkg::ANG_W:0]   n_phi_t, n_th_t;
    logic [scrd_pkg::ANG_W-1:0] r_phi, r_theta;
    logic [scrd_pkg::QN_W-1:0]  r_qx, r_qy;

    always_comb begin
        n_lam = (r_sgn_dly[DIV_N-1][0] && w_q_lam != '0) ?
                scrd_pkg::DEG_FULL - w_q_lam : w_q_lam;
        n_psi = (r_sgn_dly[DIV_N-1][1] && w_q_psi != '0) ?
                scrd_pkg::DEG_FULL - w_q_psi : w_q_psi;
        n_phi_t = {1'b0, scrd_pkg::DEG_HALF} + {1'b0, scrd_pkg::DEG_FULL} - {1'b0, n_lam};
        n_th_t  = {1'b0, scrd_pkg::DEG_QUARTER} + {1'b0, scrd_pkg::DEG_FULL}
                  - {1'b0, n_psi};
        n_phi   = (n_phi_t >= {1'b0, scrd_pkg::DEG_FULL}) ?
                  scrd_pkg::ANG_W'(n_phi_t - {1'b0, scrd_pkg::DEG_FULL}) : n_phi_t[24:0];
        n_theta = (n_th_t >= {1'b0, scrd_pkg::DEG_FULL}) ?
                  scrd_pkg::ANG_W'(n_th_t - {1'b0, scrd_pkg::DEG_FULL}) : n_th_t[24:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_phi   <= n_phi;
            r_theta <= n_theta;
            r_qx    <= (w_q_qx > scrd_pkg::QN_CAP) ? scrd_pkg::QN_CAP : w_q_qx;
            r_qy    <= (w_q_qy > scrd_pkg::QN_CAP) ? scrd_pkg::QN_CAP : w_q_qy;
        end
    end

    // fold into [-90, 90] degrees; squares for the disk test
    logic signed [scrd_pkg::Z_W-1:0] n_zp0, n_zt0, n_zp, n_zt;
    logic                            n_np, n_nt;
    logic signed [scrd_pkg::Z_W-1:0] r_zp, r_zt;
    logic                            r_np, r_nt;
    logic [63:0]                     r_sq_x, r_sq_y;

    always_comb begin
        n_zp0 = (r_phi > scrd_pkg::DEG_HALF) ?
                signed'({1'b0, r_phi}) - scrd_pkg::Z_FULL : signed'({1'b0, r_phi});
        n_zt0 = (r_theta > scrd_pkg::DEG_HALF) ?
                signed'({1'b0, r_theta}) - scrd_pkg::Z_FULL : signed'({1'b0, r_theta});
        n_zp = n_zp0;
        n_np = 1'b0;
        if (n_zp0 > scrd_pkg::Z_QUARTER) begin
            n_zp = n_zp0 - scrd_pkg::Z_HALF;
            n_np = 1'b1;
        end else if (n_zp0 < -scrd_pkg::Z_QUARTER) begin
            n_zp = n_zp0 + scrd_pkg::Z_HALF;
            n_np = 1'b1;
        end
        n_zt = n_zt0;
        n_nt = 1'b0;
        if (n_zt0 > scrd_pkg::Z_QUARTER) begin
            n_zt = n_zt0 - scrd_pkg::Z_HALF;
            n_nt = 1'b1;
        end else if (n_zt0 < -scrd_pkg::Z_QUARTER) begin
            n_zt = n_zt0 + scrd_pkg::Z_HALF;
            n_nt = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zp   <= n_zp;
            r_np   <= n_np;
            r_zt   <= n_zt;
            r_nt   <= n_nt;
            r_sq_x <= r_qx * r_qx;
            r_sq_y <= r_qy * r_qy;
        end
    end

    // sine and cosine of both angles
    logic signed [scrd_pkg::XY_W-1:0] w_cp, w_sp, w_ct, w_st;

    scrd_cordic u_cordic_phi (
        .i_clk(i_clk), .i_en(w_adv), .i_z(r_zp), .i_neg(r_np), .o_cos(w_cp), .o_sin(w_sp)
    );
    scrd_cordic u_cordic_theta (
        .i_clk(i_clk), .i_en(w_adv), .i_z(r_zt), .i_neg(r_nt), .o_cos(w_ct), .o_sin(w_st)
    );

    // disk flag delayed to match the CORDIC
    logic [64:0]       n_sq_sum;
    logic [CORD_L-1:0] r_flag_dly;
    assign n_sq_sum = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_flag_dly <= {r_flag_dly[CORD_L-2:0], (n_sq_sum <= 65'h1_0000_0000_0000_000)};
        end
    end

    // sin(theta) times sin/cos(phi), back to Q.30
    logic signed [65:0]               n_pa, n_pb;
    logic signed [33:0]               r_a, r_b;
    logic signed [scrd_pkg::XY_W-1:0] r_ct;
    logic                             r_flag1;
    assign n_pa = w_st * w_sp;
    assign n_pb = w_st * w_cp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a     <= n_pa[63:30];
            r_b     <= n_pb[63:30];
            r_ct    <= w_ct;
            r_flag1 <= r_flag_dly[CORD_L-1];
        end
    end

    // basis terms, one product per component and vector
    logic signed [49:0] r_pu [3];
    logic signed [49:0] r_pv [3];
    logic signed [49:0] r_pw [3];
    logic               r_flag2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_pu[k] <= r_a * scrd_pkg::comp16(r_bas_u, k);
                r_pv[k] <= 50'(r_ct * scrd_pkg::comp16(r_bas_v, k));
                r_pw[k] <= r_b * scrd_pkg::comp16(r_bas_w, k);
            end
            r_flag2 <= r_flag1;
        end
    end

    // sum, round half up to Q2.14, saturate
    logic signed [51:0] n_acc [3];
    logic signed [21:0] n_rnd [3];
    logic [15:0]        n_dir [3];
    logic [15:0]        r_dir [3];
    logic               r_flag3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_acc[k] = 52'(r_pu[k]) + 52'(r_pv[k]) + 52'(r_pw[k]) + 52'sd536870912;
            n_rnd[k] = n_acc[k][51:30];
            if (n_rnd[k] > 22'sd32767) begin
                n_dir[k] = 16'h7FFF;
            end else if (n_rnd[k] < -22'sd32768) begin
                n_dir[k] = 16'h8000;
            end else begin
                n_dir[k] = n_rnd[k][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dir   <= n_dir;
            r_flag3 <= r_flag2;
        end
    end

    assign o_m_tdata = {7'd0, r_flag3, r_dir[2], r_dir[1], r_dir[0]};

    // reduced angles stay below a full turn
    a_ang_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_ANG] |-> (r_phi < scrd_pkg::DEG_FULL) && (r_theta < scrd_pkg::DEG_FULL))
        else $error("reduced angle out of range");

    // folded CORDIC angles lie within a quarter turn
    a_fold_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_FOLD] |-> (r_zp <= scrd_pkg::Z_QUARTER) && (r_zp >= -scrd_pkg::Z_QUARTER)
                        && (r_zt <= scrd_pkg::Z_QUARTER) && (r_zt >= -scrd_pkg::Z_QUARTER))
        else $error("folded angle out of range");

    // a stalled output keeps the pipeline frozen
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(r_vld) && $stable(r_phi))
        else $error("pipeline moved during stall");

endmodule
